// ----- design/dpt_pkg.sv -----
package dpt_pkg;

  // result status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_STARTED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_ENDED     = 3'd4;
  localparam logic [2:0] ST_NO_CHANGE = 3'd5;

  // request function codes
  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_SWEEP  = 1'b1;

  localparam int ADDR_W   = 48;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;

  // table store word: address above last-seen time
  localparam int ENTRY_W = ADDR_W + TIME_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                slot_valid;
  } result_t;

endpackage

// ----- design/device_presence_table_unit.sv -----
// Channel   Signals                                           Direction  Handshake
// request   func, device_address, name_present, time_now      in         start && !busy
// result    status, slot_index, slot_valid                    out        done (one cycle)
// config    cfg_data (silence_timeout)                        in         cfg_write
//
// One request at a time. The sequencer walks the table through one shared
// compare unit (48-bit address match / 32-bit age compare), one entry per
// cycle, fed by the single read port of the entry RAM. A hit stops the walk;
// a miss walks all TABLE_DEPTH entries. The request is latched on accept, each
// RAM read is registered before its compare, and done is registered from the
// compare that ends the walk. busy is low in the cycle done is high, so the
// next request may be taken then. Reset clears occupied/broadcasting flags
// at once; the RAM needs no clearing since only occupied entries can hit.
// The receiver cannot stall: done is a one-cycle strobe.
module device_presence_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // request
  input  logic                            start,
  output logic                            busy,
  input  logic                            func,
  input  logic [dpt_pkg::ADDR_W-1:0]      device_address,
  input  logic                            name_present,
  input  logic [dpt_pkg::TIME_W-1:0]      time_now,
  // config
  input  logic                            cfg_write,
  input  logic [dpt_pkg::TIME_W-1:0]      cfg_data,
  // result
  output logic                            done,
  output logic [dpt_pkg::STATUS_W-1:0]    status,
  output logic [dpt_pkg::SLOT_W-1:0]      slot_index,
  output logic                            slot_valid
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state, state_next;

  // latched request
  logic                         func_q;
  logic [dpt_pkg::ADDR_W-1:0]   addr_q;
  logic                         named_q;
  logic [dpt_pkg::TIME_W-1:0]   now_q;

  logic [dpt_pkg::TIME_W-1:0]   silence_timeout;

  // walk pointers: rd_idx issues RAM reads, cmp_idx is the entry whose data is on rdata
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [IW-1:0] cmp_idx, cmp_idx_next;
  logic          cmp_vld, cmp_vld_next;
  logic          free_found, free_found_next;
  logic [IW-1:0] free_idx, free_idx_next;

  logic [TABLE_DEPTH-1:0] occupied;
  logic [TABLE_DEPTH-1:0] broadcasting;

  // RAM port
  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  logic [dpt_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [dpt_pkg::ENTRY_W-1:0]   ram_rdata;

  // shared compare unit
  logic [dpt_pkg::TIME_W-1:0] age;
  logic occ_cur, bc_cur, addr_match, age_ok, hit, last;

  // finish controls
  logic                 finish;
  logic                 bc_clr;
  dpt_pkg::result_t     res_next, res;
  logic [IW-1:0]        res_idx;
  logic [IW+dpt_pkg::SLOT_W-1:0] slot_wide;

  dpt_ram #(
    .WIDTH (dpt_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign occ_cur    = occupied[cmp_idx];
  assign bc_cur     = broadcasting[cmp_idx];
  assign addr_match = ram_rdata[dpt_pkg::ENTRY_W-1:dpt_pkg::TIME_W] == addr_q;
  // wrap-around age, modulo 2^32
  assign age        = now_q - ram_rdata[dpt_pkg::TIME_W-1:0];
  assign age_ok     = age >= silence_timeout;
  assign hit        = cmp_vld && occ_cur &&
                      ((func_q == dpt_pkg::FUNC_SWEEP) ? (bc_cur && age_ok) : addr_match);
  assign last       = cmp_vld && (cmp_idx == LAST_IDX);

  assign ram_wdata  = {addr_q, now_q};
  assign slot_wide  = {{dpt_pkg::SLOT_W{1'b0}}, res_idx};

  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    cmp_idx_next    = cmp_idx;
    cmp_vld_next    = 1'b0;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    finish          = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = cmp_idx;
    bc_clr          = 1'b0;
    res_idx         = cmp_idx;
    res_next.status     = dpt_pkg::ST_NO_CHANGE;
    res_next.slot_valid = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next      = S_WALK;
          rd_idx_next     = '0;
          free_found_next = 1'b0;
        end
      end
      S_WALK: begin
        if (rd_idx < DEPTH_C) begin
          rd_idx_next  = rd_idx + 1'b1;
          cmp_idx_next = rd_idx[IW-1:0];
          cmp_vld_next = 1'b1;
        end
        // remember lowest free slot in case of a report miss
        if (cmp_vld && !occ_cur && !free_found) begin
          free_found_next = 1'b1;
          free_idx_next   = cmp_idx;
        end
        if (hit) begin
          finish = 1'b1;
          res_next.slot_valid = 1'b1;
          if (func_q == dpt_pkg::FUNC_SWEEP) begin
            res_next.status = dpt_pkg::ST_ENDED;
            bc_clr          = 1'b1;
          end else begin
            res_next.status = bc_cur ? dpt_pkg::ST_UPDATED : dpt_pkg::ST_STARTED;
            ram_we          = 1'b1;
          end
        end else if (last) begin
          finish = 1'b1;
          if (func_q == dpt_pkg::FUNC_REPORT) begin
            if (free_found || !occ_cur) begin
              res_idx             = free_found ? free_idx : cmp_idx;
              ram_waddr           = res_idx;
              ram_we              = 1'b1;
              res_next.status     = dpt_pkg::ST_ADDED;
              res_next.slot_valid = 1'b1;
            end else begin
              res_next.status = dpt_pkg::ST_FULL;
            end
          end
        end
        if (finish) begin
          state_next   = S_IDLE;
          cmp_vld_next = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.slot_index = res_next.slot_valid ? slot_wide[dpt_pkg::SLOT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cmp_vld         <= 1'b0;
      free_found      <= 1'b0;
      occupied        <= '0;
      broadcasting    <= '0;
      silence_timeout <= '0;
      done            <= 1'b0;
    end else begin
      state      <= state_next;
      cmp_vld    <= cmp_vld_next;
      free_found <= free_found_next;
      done       <= finish;
      if (cfg_write) begin
        silence_timeout <= cfg_data;
      end
      // a nameless report still refreshes the entry but leaves it free
      if (ram_we) begin
        occupied[ram_waddr]     <= named_q;
        broadcasting[ram_waddr] <= 1'b1;
      end
      if (bc_clr) begin
        broadcasting[cmp_idx] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    cmp_idx  <= cmp_idx_next;
    free_idx <= free_idx_next;
    if (finish) begin
      res <= res_next;
    end
    if (start && !busy) begin
      func_q  <= func;
      addr_q  <= device_address;
      named_q <= name_present;
      now_q   <= time_now;
    end
  end

  assign busy       = (state != S_IDLE);
  assign status     = res.status;
  assign slot_index = res.slot_index;
  assign slot_valid = res.slot_valid;

  // result strobe lands with the sequencer back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  // one result per request: done never stays high
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // accepted request always starts a walk
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but sequencer not busy");

  // a named slot only goes with statuses that affect an entry
  a_slot_status: assert property (@(posedge clk) disable iff (rst)
    (done && slot_valid) |-> (status != dpt_pkg::ST_FULL && status != dpt_pkg::ST_NO_CHANGE))
    else $error("slot marked valid on full or no-change result");

endmodule

// ----- design/dpt_ram.sv -----
module dpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sim/device_presence_table_unit_test.sv -----
`timescale 1ns / 100ps

module device_presence_table_unit_test;

  localparam int TABLE_DEPTH = 16;
  localparam int POOL_SIZE = 24;     // more addresses than slots, so the table fills up
  localparam int PHASE_ITEMS = 188;
  localparam int NUM_PHASES = 6;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Scoreboard: keeps its own copy of the presence table and the timeout,
  // works out the status of each accepted request and checks results in order.
  class presence_scoreboard;
    logic [dpt_pkg::ADDR_W-1:0] slot_addr[TABLE_DEPTH];
    logic [dpt_pkg::TIME_W-1:0] slot_seen[TABLE_DEPTH];
    bit                         slot_occupied[TABLE_DEPTH];
    bit                         slot_broadcasting[TABLE_DEPTH];
    logic [dpt_pkg::TIME_W-1:0] silence_limit;
    dpt_pkg::result_t           pending_results[$];
    int unsigned                mismatches;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_addr[i] = '0;
        slot_seen[i] = '0;
        slot_occupied[i] = 1'b0;
        slot_broadcasting[i] = 1'b0;
      end
      silence_limit = '0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function void set_timeout(logic [dpt_pkg::TIME_W-1:0] value);
      silence_limit = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one accepted request to the table and queue its status.
    function void note_request(logic f_code, logic [dpt_pkg::ADDR_W-1:0] addr, logic named,
                               logic [dpt_pkg::TIME_W-1:0] now);
      dpt_pkg::result_t           r;
      int                         hit;
      int                         target;
      logic [dpt_pkg::TIME_W-1:0] age;
      r.status = dpt_pkg::ST_NO_CHANGE;
      r.slot_index = '0;
      r.slot_valid = 1'b0;
      hit = -1;
      target = -1;
      if (f_code == dpt_pkg::FUNC_REPORT) begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (hit < 0 && slot_occupied[i] && slot_addr[i] == addr) hit = i;
        target = hit;
        // miss: lowest free slot, occupied or not afterwards
        if (target < 0)
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (target < 0 && !slot_occupied[i]) target = i;
        if (target < 0) begin
          r.status = dpt_pkg::ST_FULL;
        end else begin
          if (hit < 0) r.status = dpt_pkg::ST_ADDED;
          else if (slot_broadcasting[hit]) r.status = dpt_pkg::ST_UPDATED;
          else r.status = dpt_pkg::ST_STARTED;
          // unnamed report refreshes the slot but leaves it free
          slot_addr[target] = addr;
          slot_occupied[target] = named;
          slot_broadcasting[target] = 1'b1;
          slot_seen[target] = now;
          r.slot_index = target[dpt_pkg::SLOT_W-1:0];
          r.slot_valid = 1'b1;
        end
      end else begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          age = now - slot_seen[i];  // wraps mod 2^32
          if (target < 0 && slot_occupied[i] && slot_broadcasting[i] && age >= silence_limit)
            target = i;
        end
        if (target >= 0) begin
          slot_broadcasting[target] = 1'b0;
          r.status = dpt_pkg::ST_ENDED;
          r.slot_index = target[dpt_pkg::SLOT_W-1:0];
          r.slot_valid = 1'b1;
        end
      end
      pending_results.push_back(r);
    endfunction

    task check_result(logic [dpt_pkg::STATUS_W-1:0] got_status,
                      logic [dpt_pkg::SLOT_W-1:0] got_slot, logic got_valid);
      dpt_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result status %0d slot %0d with no request pending",
                         got_status, got_slot));
        return;
      end
      want = pending_results.pop_front();
      if (got_status !== want.status)
        report($sformatf("status got %0d exp %0d", got_status, want.status));
      if (got_slot !== want.slot_index)
        report($sformatf("slot_index got %0d exp %0d", got_slot, want.slot_index));
      if (got_valid !== want.slot_valid)
        report($sformatf("slot_valid got %0b exp %0b", got_valid, want.slot_valid));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         func = dpt_pkg::FUNC_REPORT;
  logic [dpt_pkg::ADDR_W-1:0]   device_address = '0;
  logic                         name_present = 1'b0;
  logic [dpt_pkg::TIME_W-1:0]   time_now = '0;
  logic                         cfg_write = 1'b0;
  logic [dpt_pkg::TIME_W-1:0]   cfg_data = '0;
  logic                         done;
  logic [dpt_pkg::STATUS_W-1:0] status;
  logic [dpt_pkg::SLOT_W-1:0]   slot_index;
  logic                         slot_valid;

  presence_scoreboard sb = new();

  logic [dpt_pkg::ADDR_W-1:0] addr_pool[POOL_SIZE];
  logic [dpt_pkg::TIME_W-1:0] clock_ms;           // running time stamp, wraps freely
  int unsigned                cycle_count = 0;

  always #1 clk = ~clk;

  device_presence_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .device_address(device_address),
    .name_present(name_present),
    .time_now(time_now),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .slot_index(slot_index),
    .slot_valid(slot_valid)
  );

  // Every done strobe is a result; the receiver never stalls.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, slot_index, slot_valid);
  end

  // Watchdog: generous bound on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] watchdog expired, %0d results outstanding", $realtime, sb.pending());
      $display("device_presence_table_unit test failed");
      $finish;
    end
  end

  // Called at a rising edge. Raises start (or keeps it up from the previous
  // request) and returns at the edge where the request is taken. start is
  // left high so back-to-back requests never drop it within a step.
  task automatic send_request(logic f_code, logic [dpt_pkg::ADDR_W-1:0] addr, logic named,
                              logic [dpt_pkg::TIME_W-1:0] now);
    start <= 1'b1;
    func <= f_code;
    device_address <= addr;
    name_present <= named;
    time_now <= now;
    do @(posedge clk); while (busy);
    sb.note_request(f_code, addr, named, now);
  endtask

  // Drop start and let every outstanding result come back.
  task automatic drain_requests();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Timeout write; only issued with the table idle.
  task automatic write_timeout(logic [dpt_pkg::TIME_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_timeout(value);
  endtask

  // Mostly back-to-back or short gaps, a few long ones.
  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [dpt_pkg::ADDR_W-1:0] fresh_address();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[dpt_pkg::ADDR_W-1:0];
  endfunction

  initial begin
    logic [dpt_pkg::TIME_W-1:0] phase_timeout[NUM_PHASES];
    logic [dpt_pkg::ADDR_W-1:0] addr;
    logic                       named;
    logic                       f_code;
    int unsigned                p;
    int                         gap;

    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) addr_pool[k] = fresh_address();

    // max timeout first: a sweep one tick before wrap-around is the only hit
    phase_timeout[0] = 32'hFFFF_FFFF;
    phase_timeout[1] = 32'd1000;
    phase_timeout[2] = 32'd0;
    phase_timeout[3] = 32'd1;
    phase_timeout[4] = $urandom;
    phase_timeout[5] = $urandom_range(50, 3000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, timeout at its reset value of zero.
    send_request(dpt_pkg::FUNC_SWEEP, '0, 1'b0, '0);                 // empty table: no change
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[0], 1'b1, '0);      // added 0, all-zero address
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[1], 1'b1, '1);      // added 1, all-one, max time
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[0], 1'b1, 32'd5);   // updated 0
    send_request(dpt_pkg::FUNC_SWEEP, '1, 1'b1, '1);                 // zero timeout: ended 0
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[0], 1'b1, 32'd7);   // broadcast started again
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[2], 1'b0, 32'd8);   // unnamed miss: stays free
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[2], 1'b1, 32'd9);   // same slot, now occupied
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[2], 1'b0, 32'd10);  // unnamed hit: freed
    for (int k = 2; k < TABLE_DEPTH; k++)
      send_request(dpt_pkg::FUNC_REPORT, addr_pool[k], 1'b1, 32'd20 + k);
    send_request(dpt_pkg::FUNC_REPORT, addr_pool[TABLE_DEPTH], 1'b1, 32'd40);  // table full

    clock_ms = 32'hFFFF_F000 - $urandom_range(0, 4000);  // wrap early in the run

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_requests();
      write_timeout(phase_timeout[ph]);

      if (phase_timeout[ph] == 32'hFFFF_FFFF) begin
        // free slot 0, refill it, then sweep at an age of exactly 2^32-1
        send_request(dpt_pkg::FUNC_REPORT, addr_pool[0], 1'b0, clock_ms);
        send_request(dpt_pkg::FUNC_REPORT, fresh_address(), 1'b1, clock_ms);
        send_request(dpt_pkg::FUNC_SWEEP, '0, 1'b0, clock_ms - 1);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // first stretch of each phase runs back to back
        gap = (n < 40) ? 0 : pick_gap();
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end

        p = $urandom_range(0, 99);
        if (p < 70) clock_ms = clock_ms + $urandom_range(0, 400);
        else if (p < 92) clock_ms = clock_ms + $urandom_range(0, 5000);
        else clock_ms = $urandom;

        f_code = ($urandom_range(0, 99) < 35) ? dpt_pkg::FUNC_SWEEP : dpt_pkg::FUNC_REPORT;
        if ($urandom_range(0, 99) < 90) begin
          addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
          named = ($urandom_range(0, 3) != 0);
        end else begin
          // unknown device; mostly unnamed so the table does not clog
          addr = fresh_address();
          named = ($urandom_range(0, 4) == 0);
        end
        send_request(f_code, addr, named, clock_ms);
      end
    end

    drain_requests();
    repeat (24) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d requests without a result", sb.pending()));

    if (sb.mismatches == 0) begin
      $display("device_presence_table_unit test passed");
    end else begin
      $display("device_presence_table_unit test failed");
    end
    $finish;
  end

endmodule

// ----- device_presence_table_unit.f -----
design/dpt_pkg.sv
design/dpt_ram.sv
design/device_presence_table_unit.sv
sim/device_presence_table_unit_test.sv
